// ----- design/etr_pkg.sv -----
// ----------------------------------------------------------------------------
// Event timer package
// Shared constants, register map codes and the access bundle that the top
// level hands to each timer slice.
// ----------------------------------------------------------------------------
package etr_pkg;

  // Default number of timers.
  localparam int NUM_TIMERS_DEF = 3;

  // Item kinds carried on the mode field.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // Register word indexes (byte offset divided by eight).
  localparam logic [7:0] W_CAP    = 8'h00;
  localparam logic [7:0] W_GCFG   = 8'h02;
  localparam logic [7:0] W_COUNT  = 8'h1e;
  localparam int         W_TIMER0 = 32;
  localparam int         W_TSTEP  = 4;

  // Configuration port register indexes.
  localparam logic [1:0] CFG_PERIOD = 2'd0;
  localparam logic [1:0] CFG_REV    = 2'd1;
  localparam logic [1:0] CFG_VENDOR = 2'd2;
  localparam logic [1:0] CFG_ROUTE  = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [26:0] PERIOD_RST = 27'd69841279;
  localparam logic [7:0]  REV_RST    = 8'd1;

  // Timer settings bits.
  localparam int          T_LEVEL_BIT  = 1;
  localparam int          T_ENB_BIT    = 2;
  localparam int          T_MODE32_BIT = 8;
  localparam logic [15:0] T_WMASK      = 16'h3f06;
  localparam logic [15:0] T_SIZE_CAP   = 16'h0020;

  // One processed item as seen by a timer slice.
  typedef struct packed {
    logic        tick;   // counter advanced on this item
    logic        rd;     // register read
    logic        wr;     // register write
    logic [7:0]  word;
    logic [63:0] wdata;
    logic [63:0] count;  // counter value after the increment
  } etr_acc_t;

endpackage

// ----- design/event_timer_register_block_top.sv -----
// ----------------------------------------------------------------------------
// Event timer register block, top level
// Input register, main counter and general registers, timer slices and the
// result register.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item is a counter tick (mode 0), a 64-bit register read
//   (mode 1) or a 64-bit register write (mode 2), addressed by word index.
//   Every item yields exactly one result item: read data (zero unless a read
//   hits a mapped word), the interrupt lines of timers 0 to 2 after the item,
//   and a hit flag for mapped register accesses.
//   Both channels use valid/ready. An item is captured in the input register,
//   processed through the counter increment and one 64-bit compare per timer
//   once the result register is free or drains, and lands in the result
//   register. One item per cycle is sustained while the receiver is ready.
//   When the receiver stalls, the result register holds and the input
//   register keeps one more item; in_ready drops only when both are full.
//   The configuration port writes the capability fields and the route mask
//   directly, and is meant to be used while the block is idle.
//   Synchronous reset clears the counter, enables, timer settings and held
//   lines, and sets all comparators to all ones.
// ----------------------------------------------------------------------------
module event_timer_register_block_top #(
  parameter int NUM_TIMERS = etr_pkg::NUM_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  word_index,
  input  logic [63:0] write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] read_data,
  output logic [2:0]  timer_irq,
  output logic        access_hit
);

  // Configuration registers.
  logic [26:0] clk_period_fs;
  logic [7:0]  revision_id;
  logic [15:0] vendor_code;
  logic [31:0] route_capability;

  // Input register.
  logic        inq_valid;
  logic [1:0]  inq_mode;
  logic [7:0]  inq_word;
  logic [63:0] inq_data;

  // Block state.
  logic [63:0] main_counter;
  logic [63:0] main_counter_next;
  logic        counter_enable;
  logic        counter_enable_next;
  logic        legacy_routing;
  logic        legacy_routing_next;

  logic              go;
  logic              rd;
  logic              wr;
  logic [63:0]       count_inc;
  etr_pkg::etr_acc_t acc;
  logic [63:0]       cap_word;
  logic [63:0]       glb_rdata;
  logic              glb_hit;
  logic [63:0]       rdata_next;
  logic              hit_next;
  logic [2:0]        irq_next;

  logic [63:0] tmr_rdata [NUM_TIMERS];
  logic        tmr_hit   [NUM_TIMERS];
  logic        tmr_line  [NUM_TIMERS];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      clk_period_fs    <= etr_pkg::PERIOD_RST;
      revision_id      <= etr_pkg::REV_RST;
      vendor_code      <= '0;
      route_capability <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        etr_pkg::CFG_PERIOD: clk_period_fs    <= cfg_data[26:0];
        etr_pkg::CFG_REV:    revision_id      <= cfg_data[7:0];
        etr_pkg::CFG_VENDOR: vendor_code      <= cfg_data[15:0];
        etr_pkg::CFG_ROUTE:  route_capability <= cfg_data;
        default: ;
      endcase
    end
  end

  // The held item is processed when the result register is free or drains.
  assign go       = inq_valid && (!out_valid || out_ready);
  assign in_ready = !inq_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      inq_mode <= mode;
      inq_word <= word_index;
      inq_data <= write_data;
    end
  end

  // Qualified access strobes and the bundle for the timer slices.
  assign rd        = go && (inq_mode == etr_pkg::MODE_READ);
  assign wr        = go && (inq_mode == etr_pkg::MODE_WRITE);
  assign count_inc = main_counter + 64'd1;

  always_comb begin
    acc.tick  = go && (inq_mode == etr_pkg::MODE_TICK) && counter_enable;
    acc.rd    = rd;
    acc.wr    = wr;
    acc.word  = inq_word;
    acc.wdata = inq_data;
    acc.count = count_inc;
  end

  assign cap_word = {5'b0, clk_period_fs, vendor_code, 1'b1, 1'b0, 1'b1,
                     5'(NUM_TIMERS - 1), revision_id};

  // Counter, general config and capability decode.
  always_comb begin
    main_counter_next   = main_counter;
    counter_enable_next = counter_enable;
    legacy_routing_next = legacy_routing;
    glb_rdata           = '0;
    glb_hit             = 1'b0;
    if (acc.tick) begin
      main_counter_next = count_inc;
    end
    if (rd || wr) begin
      case (inq_word)
        etr_pkg::W_CAP: begin
          glb_hit = 1'b1;
          if (rd) begin
            glb_rdata = cap_word;
          end
        end
        etr_pkg::W_GCFG: begin
          glb_hit = 1'b1;
          if (wr) begin
            counter_enable_next = inq_data[0];
            legacy_routing_next = inq_data[1];
          end else begin
            glb_rdata = {62'd0, legacy_routing, counter_enable};
          end
        end
        etr_pkg::W_COUNT: begin
          glb_hit = 1'b1;
          if (wr) begin
            main_counter_next = inq_data;
          end else begin
            glb_rdata = main_counter;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_counter   <= '0;
      counter_enable <= 1'b0;
      legacy_routing <= 1'b0;
    end else begin
      main_counter   <= main_counter_next;
      counter_enable <= counter_enable_next;
      legacy_routing <= legacy_routing_next;
    end
  end

  // Timer slices.
  for (genvar n = 0; n < NUM_TIMERS; n++) begin : g_tmr
    etr_timer #(
      .IDX(n)
    ) u_tmr (
      .clk       (clk),
      .rst       (rst),
      .acc       (acc),
      .route_cap (route_capability),
      .rdata     (tmr_rdata[n]),
      .hit       (tmr_hit[n]),
      .line      (tmr_line[n])
    );
  end

  // Only timers 0 to 2 have an interrupt line.
  for (genvar b = 0; b < 3; b++) begin : g_irq
    if (b < NUM_TIMERS) begin : g_on
      assign irq_next[b] = tmr_line[b];
    end else begin : g_off
      assign irq_next[b] = 1'b0;
    end
  end

  // Merge read data and hit from all decoders; at most one is active.
  always_comb begin
    rdata_next = glb_rdata;
    hit_next   = glb_hit;
    for (int n = 0; n < NUM_TIMERS; n++) begin
      rdata_next = rdata_next | tmr_rdata[n];
      hit_next   = hit_next | tmr_hit[n];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      read_data  <= rdata_next;
      timer_irq  <= irq_next;
      access_hit <= hit_next;
    end
  end

endmodule

// ----- design/etr_timer.sv -----
// ----------------------------------------------------------------------------
// Event timer slice
// One timer: settings, comparator, held level line, match logic and its
// share of the register read and hit decode.
// ----------------------------------------------------------------------------
module etr_timer #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  etr_pkg::etr_acc_t acc,
  input  logic [31:0]       route_cap,
  output logic [63:0]       rdata,
  output logic              hit,
  output logic              line
);

  localparam logic [7:0] CfgWord = 8'(etr_pkg::W_TIMER0 + etr_pkg::W_TSTEP * IDX);
  localparam logic [7:0] CmpWord = 8'(etr_pkg::W_TIMER0 + etr_pkg::W_TSTEP * IDX + 1);

  logic [15:0] settings;
  logic [15:0] settings_next;
  logic [63:0] compare;
  logic [63:0] compare_next;
  logic        fired;
  logic        fired_next;

  logic        is_cfg;
  logic        is_cmp;
  logic        match;
  logic        fire;
  logic [15:0] wr_settings;

  assign is_cfg      = (acc.word == CfgWord);
  assign is_cmp      = (acc.word == CmpWord);
  assign wr_settings = acc.wdata[15:0] & etr_pkg::T_WMASK;

  // Comparator match; 32-bit mode looks at the low half only.
  always_comb begin
    if (settings[etr_pkg::T_MODE32_BIT]) begin
      match = (acc.count[31:0] == compare[31:0]);
    end else begin
      match = (acc.count == compare);
    end
  end

  assign fire = acc.tick && match && settings[etr_pkg::T_ENB_BIT];

  // Next state of settings, comparator and the held level line.
  always_comb begin
    settings_next = settings;
    compare_next  = compare;
    fired_next    = fired;
    if (acc.wr && is_cfg) begin
      settings_next = wr_settings;
      if (!wr_settings[etr_pkg::T_ENB_BIT] || !wr_settings[etr_pkg::T_LEVEL_BIT]) begin
        fired_next = 1'b0;
      end
    end else if (acc.wr && is_cmp) begin
      compare_next = acc.wdata;
      fired_next   = 1'b0;
    end else if (fire && settings[etr_pkg::T_LEVEL_BIT]) begin
      fired_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settings <= '0;
      compare  <= '1;
      fired    <= 1'b0;
    end else begin
      settings <= settings_next;
      compare  <= compare_next;
      fired    <= fired_next;
    end
  end

  // Read data and hit for this timer's two words.
  always_comb begin
    rdata = '0;
    if (acc.rd && is_cfg) begin
      rdata = {route_cap, 16'h0000, settings | etr_pkg::T_SIZE_CAP};
    end else if (acc.rd && is_cmp) begin
      rdata = compare;
    end
  end

  assign hit  = (acc.rd || acc.wr) && (is_cfg || is_cmp);
  assign line = fired_next || (fire && !settings[etr_pkg::T_LEVEL_BIT]);

endmodule
